// ===== rtl/key_value_pair_sorter_defines.svh =====
// assertion macros for the key/value pair sorter
`ifndef KEY_VALUE_PAIR_SORTER_DEFINES_SVH
`define KEY_VALUE_PAIR_SORTER_DEFINES_SVH

`ifndef SYNTH
// checked only while out of reset
`define KVPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define KVPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define KVPS_ASSERT(lbl, prop, msg)
`define KVPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/kvps_pkg.sv =====
// shared types and defaults of the key/value pair sorter
package kvps_pkg;

  localparam int unsigned DepthDefault      = 32;
  localparam int unsigned KeyWidthDefault   = 32;
  localparam int unsigned ValueWidthDefault = 32;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctrl_t;

endpackage

// ===== rtl/kvps_cell.sv =====
// one cell of the sorting chain: holds one pair, inserts in order or shifts out
module kvps_cell #(
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  kvps_pkg::cell_ctrl_t          ctrl_i,
  input  logic                          occupied_i,
  input  logic                          prev_gt_i,
  output logic                          gt_o,
  input  logic signed [KEY_WIDTH-1:0]   ins_key_i,
  input  logic        [VALUE_WIDTH-1:0] ins_value_i,
  input  logic signed [KEY_WIDTH-1:0]   prev_key_i,
  input  logic        [VALUE_WIDTH-1:0] prev_value_i,
  input  logic signed [KEY_WIDTH-1:0]   next_key_i,
  input  logic        [VALUE_WIDTH-1:0] next_value_i,
  output logic signed [KEY_WIDTH-1:0]   key_o,
  output logic        [VALUE_WIDTH-1:0] value_o
);
  import kvps_pkg::*;

  logic signed [KEY_WIDTH-1:0]   key_q, key_d;
  logic        [VALUE_WIDTH-1:0] value_q, value_d;

  // strictly greater keeps equal keys ahead of the new one
  assign gt_o = !occupied_i || (key_q > ins_key_i);

  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    priority if (ctrl_i.shift_out) begin
      key_d   = next_key_i;
      value_d = next_value_i;
    end else if (ctrl_i.insert && gt_o) begin
      if (prev_gt_i) begin
        key_d   = prev_key_i;
        value_d = prev_value_i;
      end else begin
        key_d   = ins_key_i;
        value_d = ins_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o   = key_q;
  assign value_o = value_q;

endmodule

// ===== rtl/key_value_pair_sorter.sv =====
// key/value pair sorter: insertion chain of cells, ascending signed key, stable
// a pair is accepted every cycle while busy is low; it is placed in order on acceptance unless the store is full
// after the batch_end transaction, busy stays high until every pair held is shifted out
// results follow at one per cycle through a result register that samples cell zero
// the emission is done by shifting the chain out through cell zero
// reset clears fill count, overflow flag, state and result valid; cell contents are not cleared
`include "key_value_pair_sorter_defines.svh"

module key_value_pair_sorter #(
  parameter int unsigned DEPTH       = kvps_pkg::DepthDefault,
  parameter int unsigned KEY_WIDTH   = kvps_pkg::KeyWidthDefault,
  parameter int unsigned VALUE_WIDTH = kvps_pkg::ValueWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [KEY_WIDTH-1:0]   key_in_i,
  input  logic        [VALUE_WIDTH-1:0] value_in_i,
  input  logic                          batch_end_i,
  output logic                          result_valid_o,
  output logic signed [KEY_WIDTH-1:0]   key_out_o,
  output logic        [VALUE_WIDTH-1:0] value_out_o,
  output logic                          last_out_o,
  output logic                          dropped_o
);
  import kvps_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic            accept, store_full;
  cell_ctrl_t      ctrl;

  logic signed [KEY_WIDTH-1:0]   key_w   [DEPTH];
  logic        [VALUE_WIDTH-1:0] value_w [DEPTH];
  logic                          gt_w    [DEPTH];

  logic                          res_valid_q;
  logic signed [KEY_WIDTH-1:0]   res_key_q;
  logic        [VALUE_WIDTH-1:0] res_value_q;
  logic                          res_last_q, res_dropped_q;

  assign busy       = (state_q == ST_EMIT);
  assign accept     = start && !busy;
  assign store_full = (count_q == CntW'(DEPTH));

  assign ctrl.insert    = accept && !store_full;
  assign ctrl.shift_out = busy;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0]   prev_key, next_key;
    logic        [VALUE_WIDTH-1:0] prev_value, next_value;
    logic                          prev_gt;

    if (i == 0) begin : g_first
      assign prev_key   = key_in_i;
      assign prev_value = value_in_i;
      assign prev_gt    = 1'b0;
    end else begin : g_inner
      assign prev_key   = key_w[i-1];
      assign prev_value = value_w[i-1];
      assign prev_gt    = gt_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_key   = '0;
      assign next_value = '0;
    end else begin : g_mid
      assign next_key   = key_w[i+1];
      assign next_value = value_w[i+1];
    end

    kvps_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (count_q > CntW'(i)),
      .prev_gt_i   (prev_gt),
      .gt_o        (gt_w[i]),
      .ins_key_i   (key_in_i),
      .ins_value_i (value_in_i),
      .prev_key_i  (prev_key),
      .prev_value_i(prev_value),
      .next_key_i  (next_key),
      .next_value_i(next_value),
      .key_o       (key_w[i]),
      .value_o     (value_w[i])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (store_full) begin
            ovf_d = 1'b1;
          end else begin
            count_d = count_q + CntW'(1);
          end
          if (batch_end_i) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        count_d = count_q - CntW'(1);
        if (count_q == CntW'(1)) begin
          state_d = ST_IDLE;
          ovf_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      res_valid_q <= busy;
    end
  end

  always_ff @(posedge clk_i) begin
    res_key_q     <= key_w[0];
    res_value_q   <= value_w[0];
    res_last_q    <= busy && (count_q == CntW'(1));
    res_dropped_q <= ovf_q;
  end

  assign result_valid_o = res_valid_q;
  assign key_out_o      = res_key_q;
  assign value_out_o    = res_value_q;
  assign last_out_o     = res_last_q && res_valid_q;
  assign dropped_o      = res_dropped_q;

  `KVPS_ASSERT(a_strobe_from_emit, result_valid_o |-> $past(busy), "result without emission")
  `KVPS_ASSERT(a_end_starts_emit, (accept && batch_end_i) |=> busy, "batch end did not emit")
  `KVPS_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "fill count beyond store size")
  `KVPS_ASSERT(a_ascending,
      (result_valid_o && !last_out_o) |=> (result_valid_o && key_out_o >= $past(key_out_o)),
      "results out of order")
  `KVPS_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!busy && !result_valid_o),
      "not idle in reset")

endmodule
